### rtl/core/tipcov_pkg.sv
`timescale 1ns / 1ps
package tipcov_pkg;

  localparam int MAP_INDEX_BITS = 16;
  // Bitmap rows are up to 64 bits wide; the rest of the index selects the row.
  localparam int ROW_SEL_BITS   = (MAP_INDEX_BITS >= 12) ? 6 : (MAP_INDEX_BITS / 2);
  localparam int ROW_BITS       = 1 << ROW_SEL_BITS;
  localparam int ROW_ADDR_BITS  = MAP_INDEX_BITS - ROW_SEL_BITS;
  localparam int ROWS           = 1 << ROW_ADDR_BITS;

  localparam int IP_W  = 64;
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic       OP_PACKET = 1'b0;
  localparam logic       OP_START  = 1'b1;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_TIP   = 2'd1;

  localparam logic [2:0] IPC_SUPPRESSED = 3'd0;
  localparam logic [2:0] IPC_UPD16      = 3'd1;
  localparam logic [2:0] IPC_UPD32      = 3'd2;
  localparam logic [2:0] IPC_UPD48      = 3'd3;
  localparam logic [2:0] IPC_SEXT48     = 3'd4;
  localparam logic [2:0] IPC_FULL       = 3'd5;

  typedef struct packed {
    logic                      start;
    logic                      ip_updated;
    logic [IP_W-1:0]           full_ip;
    logic                      mark;
    logic [MAP_INDEX_BITS-1:0] idx;
  } item_t;

endpackage

### rtl/core/tipcov_front.sv
`timescale 1ns / 1ps
module tipcov_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_op,
  input  logic [1:0]            in_pkt_kind,
  input  logic [2:0]            in_ip_compression,
  input  logic [63:0]           in_ip_payload,
  output logic                  in_stall,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_wdata,
  input  logic                  q_full,
  input  logic                  back_busy,
  output logic                  push,
  output tipcov_pkg::item_t     push_item
);
  import tipcov_pkg::*;

  logic [IP_W-1:0] cutoff_r;
  logic [IP_W-1:0] last_ip_r;
  logic [IP_W-1:0] ip_nxt;
  logic            upd;

  assign in_stall = q_full | back_busy;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    ip_nxt = last_ip_r;
    upd    = 1'b0;
    if (in_op == OP_START) begin
      ip_nxt = '0;
    end else if (in_pkt_kind != KIND_OTHER) begin
      upd = 1'b1;
      unique case (in_ip_compression)
        IPC_UPD16:  ip_nxt = {last_ip_r[63:16], in_ip_payload[15:0]};
        IPC_UPD32:  ip_nxt = {last_ip_r[63:32], in_ip_payload[31:0]};
        IPC_UPD48:  ip_nxt = {last_ip_r[63:48], in_ip_payload[47:0]};
        IPC_SEXT48: ip_nxt = {{16{in_ip_payload[47]}}, in_ip_payload[47:0]};
        IPC_FULL:   ip_nxt = in_ip_payload;
        default:    upd    = 1'b0;
      endcase
    end
  end

  always_comb begin
    push_item.start      = (in_op == OP_START);
    push_item.ip_updated = upd;
    push_item.full_ip    = ip_nxt;
    push_item.mark       = upd & (in_pkt_kind == KIND_TIP) & (ip_nxt < cutoff_r);
    push_item.idx        = ip_nxt[MAP_INDEX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= '1;
      last_ip_r <= '0;
    end else begin
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
      if (push) begin
        last_ip_r <= ip_nxt;
      end
    end
  end

endmodule

### rtl/core/tipcov_queue.sv
`timescale 1ns / 1ps
module tipcov_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tipcov_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output tipcov_pkg::item_t head
);
  import tipcov_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign full  = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (fill_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/tipcov_back.sv
`timescale 1ns / 1ps
module tipcov_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  tipcov_pkg::item_t              q_head,
  output logic                           pop,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ip_updated,
  output logic [63:0]                    out_full_ip,
  output logic                           out_new_block,
  output logic [tipcov_pkg::CNT_W-1:0]   out_new_block_count
);
  import tipcov_pkg::*;

  logic [ROW_BITS-1:0]      mem [ROWS];
  logic [ROW_BITS-1:0]      rd_data_r;

  logic                     clr_busy_r;
  logic [ROW_ADDR_BITS-1:0] clr_addr_r;

  logic                     r_valid_r;
  item_t                    r_item_r;

  logic                     fwd_valid_r;
  logic [ROW_ADDR_BITS-1:0] fwd_addr_r;
  logic [ROW_BITS-1:0]      fwd_data_r;

  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;

  logic                     out_valid_r;
  logic                     out_ip_updated_r;
  logic [IP_W-1:0]          out_full_ip_r;
  logic                     out_new_block_r;
  logic [CNT_W-1:0]         out_count_r;

  logic                     r_move;
  logic [ROW_ADDR_BITS-1:0] q_row;
  logic [ROW_ADDR_BITS-1:0] r_row;
  logic [ROW_SEL_BITS-1:0]  r_sel;
  logic [ROW_BITS-1:0]      cur_row;
  logic [ROW_BITS-1:0]      set_row;
  logic                     fresh;
  logic                     mem_we;
  logic [ROW_ADDR_BITS-1:0] mem_waddr;
  logic [ROW_BITS-1:0]      mem_wdata;

  assign busy   = clr_busy_r;
  assign r_move = r_valid_r & (~out_valid_r | ~out_stall);
  assign pop    = ~q_empty & ~clr_busy_r & (~r_valid_r | r_move);

  assign q_row = q_head.idx[MAP_INDEX_BITS-1:ROW_SEL_BITS];
  assign r_row = r_item_r.idx[MAP_INDEX_BITS-1:ROW_SEL_BITS];
  assign r_sel = r_item_r.idx[ROW_SEL_BITS-1:0];

  // The row read at the edge of the previous write misses it; take the written copy.
  assign cur_row = (fwd_valid_r && fwd_addr_r == r_row) ? fwd_data_r : rd_data_r;
  assign set_row = cur_row | (ROW_BITS'(1) << r_sel);
  assign fresh   = r_item_r.mark & ~cur_row[r_sel];

  always_comb begin
    if (r_item_r.start) begin
      cnt_nxt = '0;
    end else if (fresh && cnt_r != COUNT_MAX) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = r_move & r_item_r.mark;
      mem_waddr = r_row;
      mem_wdata = set_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[q_row];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_item_r <= q_head;
    end
    if (r_move && r_item_r.mark) begin
      fwd_addr_r <= r_row;
      fwd_data_r <= set_row;
    end
    if (r_move) begin
      out_ip_updated_r <= r_item_r.ip_updated;
      out_full_ip_r    <= r_item_r.full_ip;
      out_new_block_r  <= fresh;
      out_count_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      r_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        r_valid_r <= 1'b1;
      end else if (r_move) begin
        r_valid_r <= 1'b0;
      end
      if (r_move && r_item_r.mark) begin
        fwd_valid_r <= 1'b1;
      end
      if (r_move) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ip_updated      = out_ip_updated_r;
  assign out_full_ip         = out_full_ip_r;
  assign out_new_block       = out_new_block_r;
  assign out_new_block_count = out_count_r;

endmodule

### rtl/core/trace_ip_coverage_tracker.sv
`timescale 1ns / 1ps
// Trace IP coverage tracker. Takes one decoded trace packet per cycle while in_stall is
// low, rebuilds the target IP of tip / tip_pge / tip_pgd packets from the last IP, and
// for tip packets below cfg cutoff marks the low index bits of the IP in a coverage
// bitmap, counting bits that were newly set. Every transaction gives exactly one
// result. Sustained rate is one transaction per clock when neither side stalls: the
// front rebuilds the IP in the accept cycle, a four-entry queue decouples it from the
// back end, and the back end does the bitmap read-modify-write in a row memory with
// one read and one write port and write forwarding. An accepted input passes through
// the queue slot, the row read register and the output register. After reset the
// bitmap is cleared one row per cycle (1024 rows with a 16-bit index), during which
// in_stall stays high; cutoff writes are taken at any time.
module trace_ip_coverage_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [1:0]                   in_pkt_kind,
  input  logic [2:0]                   in_ip_compression,
  input  logic [63:0]                  in_ip_payload,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ip_updated,
  output logic [63:0]                  out_full_ip,
  output logic                         out_new_block,
  output logic [tipcov_pkg::CNT_W-1:0] out_new_block_count,
  input  logic                         cfg_we,
  input  logic [63:0]                  cfg_wdata
);
  import tipcov_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_empty;
  item_t q_head;
  logic  pop;
  logic  back_busy;

  tipcov_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_op             (in_op),
    .in_pkt_kind       (in_pkt_kind),
    .in_ip_compression (in_ip_compression),
    .in_ip_payload     (in_ip_payload),
    .in_stall          (in_stall),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_full            (q_full),
    .back_busy         (back_busy),
    .push              (push),
    .push_item         (push_item)
  );

  tipcov_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tipcov_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .pop                 (pop),
    .busy                (back_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ip_updated      (out_ip_updated),
    .out_full_ip         (out_full_ip),
    .out_new_block       (out_new_block),
    .out_new_block_count (out_new_block_count)
  );

endmodule

### verif/trace_ip_coverage_tracker_test.sv
`timescale 1ns / 1ps
module trace_ip_coverage_tracker_test;
  import tipcov_pkg::*;

  localparam logic [1:0] KIND_PGE   = 2'd2;
  localparam logic [1:0] KIND_PGD   = 2'd3;
  localparam logic [2:0] IPC_RSVD6  = 3'd6;
  localparam logic [2:0] IPC_RSVD7  = 3'd7;
  localparam int MAP_SIZE           = 1 << MAP_INDEX_BITS;
  localparam int CYCLE_LIMIT        = 200000;
  localparam int RANDOM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE    = 234;
  localparam int DIRECTED_ROWS      = 20;
  localparam int MAX_REPORTS        = 100;

  typedef struct packed {
    logic             ip_updated;
    logic [IP_W-1:0]  full_ip;
    logic             new_block;
    logic [CNT_W-1:0] new_block_count;
  } trace_result_t;

  typedef struct packed {
    logic            op;
    logic [1:0]      kind;
    logic [2:0]      mode;
    logic [IP_W-1:0] payload;
    logic            literal_valid;
    trace_result_t   literal_result;
  } directed_row_t;

  localparam trace_result_t NO_LITERAL = '0;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_op = OP_PACKET;
  logic [1:0]       in_pkt_kind = KIND_OTHER;
  logic [2:0]       in_ip_compression = IPC_SUPPRESSED;
  logic [63:0]      in_ip_payload = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_ip_updated;
  logic [63:0]      out_full_ip;
  logic             out_new_block;
  logic [CNT_W-1:0] out_new_block_count;
  logic             cfg_we = 1'b0;
  logic [63:0]      cfg_wdata = '0;

  // Predictor state
  logic [IP_W-1:0]  tracked_last_ip = '0;
  logic [IP_W-1:0]  tracked_cutoff = '1;
  logic [CNT_W-1:0] covered_count = '0;
  bit               coverage_seen [MAP_SIZE];

  trace_result_t    expected_results [$];
  directed_row_t    directed_rows [DIRECTED_ROWS];
  int               send_idle_pct = 17;
  int               recv_idle_pct = 63;
  int               mismatch_count = 0;
  int               result_count = 0;
  int               cycle_count = 0;

  trace_ip_coverage_tracker dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_pkt_kind         (in_pkt_kind),
    .in_ip_compression   (in_ip_compression),
    .in_ip_payload       (in_ip_payload),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ip_updated      (out_ip_updated),
    .out_full_ip         (out_full_ip),
    .out_new_block       (out_new_block),
    .out_new_block_count (out_new_block_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic trace_result_t track_packet(input logic op, input logic [1:0] kind,
                                                 input logic [2:0] mode,
                                                 input logic [IP_W-1:0] payload);
    trace_result_t             res;
    logic [IP_W-1:0]           ip;
    logic                      rebuilt;
    logic [MAP_INDEX_BITS-1:0] idx;
    res = '0;
    ip = tracked_last_ip;
    rebuilt = 1'b1;
    if (op == OP_START) begin
      tracked_last_ip = '0;
      covered_count = '0;
    end else if (kind != KIND_OTHER) begin
      case (mode)
        IPC_UPD16:  ip = {tracked_last_ip[63:16], payload[15:0]};
        IPC_UPD32:  ip = {tracked_last_ip[63:32], payload[31:0]};
        IPC_UPD48:  ip = {tracked_last_ip[63:48], payload[47:0]};
        IPC_SEXT48: ip = {{16{payload[47]}}, payload[47:0]};
        IPC_FULL:   ip = payload;
        default:    rebuilt = 1'b0;
      endcase
      if (rebuilt) begin
        tracked_last_ip = ip;
        res.ip_updated = 1'b1;
        // only plain tip packets below the cutoff touch the bitmap
        if (kind == KIND_TIP && ip < tracked_cutoff) begin
          idx = ip[MAP_INDEX_BITS-1:0];
          if (!coverage_seen[idx]) begin
            coverage_seen[idx] = 1'b1;
            res.new_block = 1'b1;
            if (covered_count != COUNT_MAX) covered_count = covered_count + 1'b1;
          end
        end
      end
    end
    res.full_ip = tracked_last_ip;
    res.new_block_count = covered_count;
    return res;
  endfunction

  task automatic send_packet(input logic op, input logic [1:0] kind, input logic [2:0] mode,
                             input logic [IP_W-1:0] payload, input logic literal_valid,
                             input trace_result_t literal_result);
    trace_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_ip_payload <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pkt_kind <= kind;
    in_ip_compression <= mode;
    in_ip_payload <= payload;
    do @(posedge clk); while (in_stall);
    predicted = track_packet(op, kind, mode, payload);
    expected_results.push_back(literal_valid ? literal_result : predicted);
  endtask

  task automatic send_random_packet();
    logic            op;
    logic [1:0]      kind;
    logic [2:0]      mode;
    logic [IP_W-1:0] payload;
    int              pick;
    op = ($urandom_range(0, 99) < 3) ? OP_START : OP_PACKET;
    pick = $urandom_range(0, 99);
    kind = (pick < 60) ? KIND_TIP : (pick < 75) ? KIND_PGE : (pick < 90) ? KIND_PGD : KIND_OTHER;
    pick = $urandom_range(0, 99);
    if (pick < 8) mode = IPC_SUPPRESSED;
    else if (pick < 12) mode = $urandom_range(0, 1) ? IPC_RSVD6 : IPC_RSVD7;
    else mode = 3'($urandom_range(int'(IPC_UPD16), int'(IPC_FULL)));
    payload = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    // steer toward revisited bitmap entries and the cutoff boundary
    if (pick < 45) payload[15:0] = 16'($urandom_range(0, 511));
    else if (pick < 65) payload = tracked_cutoff + 64'($urandom_range(0, 4)) - 64'd2;
    send_packet(op, kind, mode, payload, 1'b0, NO_LITERAL);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cutoff(input logic [IP_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracked_cutoff = value;
  endtask

  always @(posedge clk) begin
    trace_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction: upd=%0b ip=%h blk=%0b cnt=%0d", $time,
                   out_ip_updated, out_full_ip, out_new_block, out_new_block_count);
      end else begin
        want = expected_results.pop_front();
        if (out_ip_updated !== want.ip_updated || out_full_ip !== want.full_ip ||
            out_new_block !== want.new_block ||
            out_new_block_count !== want.new_block_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: transaction %0d expected upd=%0b ip=%h blk=%0b cnt=%0d, actual upd=%0b ip=%h blk=%0b cnt=%0d",
                     $time, result_count, want.ip_updated, want.full_ip, want.new_block,
                     want.new_block_count, out_ip_updated, out_full_ip, out_new_block,
                     out_new_block_count);
        end
      end
    end
  end

  initial begin
    logic [IP_W-1:0] phase_cutoff [RANDOM_PHASES];
    directed_rows = '{
      // packets with no effect right after reset, then two tip packets to IP 0
      '{OP_PACKET, KIND_OTHER, IPC_FULL,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0, 17'd0}},
      '{OP_PACKET, KIND_TIP,   IPC_SUPPRESSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0, 17'd0}},
      '{OP_PACKET, KIND_TIP,   IPC_RSVD6,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0, 17'd0}},
      '{OP_PACKET, KIND_PGD,   IPC_RSVD7,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0, 17'd0}},
      '{OP_PACKET, KIND_TIP,   IPC_FULL,       64'h0,                   1'b1, '{1'b1, 64'h0, 1'b1, 17'd1}},
      '{OP_PACKET, KIND_TIP,   IPC_FULL,       64'h0,                   1'b1, '{1'b1, 64'h0, 1'b0, 17'd1}},
      // all ones sits at the reset cutoff, so it is not recorded
      '{OP_PACKET, KIND_TIP,   IPC_FULL,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 17'd1}},
      '{OP_PACKET, KIND_TIP,   IPC_UPD16,      64'h1234_5678_9ABC_0000, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_PGE,   IPC_UPD32,      64'h1234_5678_9ABC_DEF0, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_PGD,   IPC_UPD48,      64'hFEDC_0000_1111_2222, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_TIP,   IPC_SEXT48,     64'h0000_8000_0000_0001, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_TIP,   IPC_SEXT48,     64'hFFFF_7FFF_FFFF_FFFF, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_PGE,   IPC_FULL,       64'h0000_0000_0000_0005, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_TIP,   IPC_UPD16,      64'hAAAA_AAAA_AAAA_0005, 1'b0, NO_LITERAL},
      // trace start ignores the packet fields and keeps the bitmap
      '{OP_START,  KIND_TIP,   IPC_FULL,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0, 17'd0}},
      '{OP_PACKET, KIND_TIP,   IPC_FULL,       64'h0,                   1'b1, '{1'b1, 64'h0, 1'b0, 17'd0}},
      '{OP_PACKET, KIND_TIP,   IPC_FULL,       64'h0000_0000_0001_0000, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_PGD,   IPC_FULL,       64'h5555_5555_5555_5555, 1'b0, NO_LITERAL},
      '{OP_PACKET, KIND_OTHER, IPC_UPD16,      64'h0000_0000_0000_BEEF, 1'b0, NO_LITERAL},
      '{OP_START,  KIND_OTHER, IPC_SUPPRESSED, 64'h0,                   1'b1, '{1'b0, 64'h0, 1'b0, 17'd0}}
    };
    phase_cutoff = '{64'h0, 64'h0000_7FFF_FFFF_0000, {$urandom, $urandom},
                     64'h0000_0000_0000_0100, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_packet(directed_rows[i].op, directed_rows[i].kind, directed_rows[i].mode,
                  directed_rows[i].payload, directed_rows[i].literal_valid,
                  directed_rows[i].literal_result);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_cutoff(phase_cutoff[phase]);
      repeat (ITEMS_PER_PHASE) send_random_packet();
      drain_results();
    end

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
